// File: hdl/wst_pkg.sv
// Shared types, widths and register indexes for the wheel step trajectory tracker.
// Used by wst_step_logic and wheel_step_trajectory_tracker; depends on nothing.
`default_nettype none
package wst_pkg;

   // encoder count width and settle counter width
   localparam int COUNT_BITS  = 32;
   localparam int SETTLE_BITS = 16;
   localparam int TOTAL_BITS  = 31;
   localparam int STEP_BITS   = 16;
   localparam int MODE_BITS   = 2;
   localparam int CSR_BITS    = 3;
   localparam int CSR_DATA_BITS = TOTAL_BITS;

   // working width for error math: the wider of a count and a signed distance,
   // plus headroom for add, abs and subtract
   localparam int WIDE_BITS = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS + 1;
   localparam int ERR_BITS  = WIDE_BITS + 3;

   typedef logic signed [COUNT_BITS-1:0] count_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic [TOTAL_BITS-1:0]        cursor_type;
   typedef logic [SETTLE_BITS-1:0]       settle_type;

   // register indexes
   typedef enum logic [CSR_BITS-1:0] {
      CSR_TOTAL_TICKS  = 3'd0,
      CSR_MOTION_MODE  = 3'd1,
      CSR_TRAJ_STEP    = 3'd2,
      CSR_ERROR_TOL    = 3'd3,
      CSR_SETTLE_TICKS = 3'd4
   } csr_index_type;

   // motion modes
   typedef enum logic [MODE_BITS-1:0] {
      MODE_FORWARD  = 2'd0,
      MODE_BACKWARD = 2'd1,
      MODE_CCW      = 2'd2,
      MODE_CW       = 2'd3
   } motion_mode_type;

   // input op codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef struct packed {
      logic [TOTAL_BITS-1:0]  move_length;
      logic [MODE_BITS-1:0]   motion_mode;
      logic [STEP_BITS-1:0]   trajectory_step;
      logic [STEP_BITS-1:0]   error_tolerance;
      logic [SETTLE_BITS-1:0] settle_ticks_needed;
   } cfg_type;

   typedef struct packed {
      count_type  right_reference;
      count_type  left_reference;
      cursor_type progress_cursor;
      settle_type settle_count;
      logic       move_done;
      logic       right_negative;
      logic       left_negative;
   } track_state_type;

   typedef struct packed {
      count_type right_setpoint;
      count_type left_setpoint;
      logic      drive_valid;
      logic      finished;
   } result_type;

   // absolute value in the working width (never overflows, headroom is kept)
   function automatic err_type abs_err(input err_type v);
      return v[ERR_BITS-1] ? -v : v;
   endfunction

   // sign-extend a count into the working width
   function automatic err_type ext_count(input count_type v);
      return err_type'(v);
   endfunction

   // zero-extend an unsigned 31-bit quantity into the working width
   function automatic err_type ext_total(input logic [TOTAL_BITS-1:0] v);
      return err_type'({{(ERR_BITS-TOTAL_BITS){1'b0}}, v});
   endfunction

   function automatic err_type ext_small(input logic [STEP_BITS-1:0] v);
      return err_type'({{(ERR_BITS-STEP_BITS){1'b0}}, v});
   endfunction

endpackage
`default_nettype wire

// File: hdl/wheel_step_trajectory_tracker.sv
// Top level of the wheel step trajectory tracker: registers, handshake, config.
// Depends on wst_pkg and wst_step_logic.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | op, right_count, left_count
//   rsp     | out       | rsp_valid/rsp_ready   | setpoints, drive_valid, finished
//   csr     | in        | csr_write_en          | csr_index, csr_data
//
// One item per cycle sustained while rsp_ready does not stall; each item waits in the
// input register and its result is loaded into the output register when it advances,
// so rsp_valid rises after the item has passed both register stages (two register stages).
// Between the two registers lies a single combinational pass in wst_step_logic.
// Synchronous active-high reset clears config, tracking state and both valids.
// A stalled result holds the output register; the input register still takes a
// new transfer whenever the item in it can move on in the same cycle.
`default_nettype none
module wheel_step_trajectory_tracker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_op,
   input  wire wst_pkg::count_type                req_right_count,
   input  wire wst_pkg::count_type                req_left_count,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output wst_pkg::count_type                     rsp_right_setpoint,
   output wst_pkg::count_type                     rsp_left_setpoint,
   output logic                                   rsp_drive_valid,
   output logic                                   rsp_finished,
   input  wire logic                              csr_write_en,
   input  wire logic [wst_pkg::CSR_BITS-1:0]      csr_index,
   input  wire logic [wst_pkg::CSR_DATA_BITS-1:0] csr_data
);

   logic                     in_valid_ff;
   logic                     in_op_ff;
   wst_pkg::count_type       in_right_ff;
   wst_pkg::count_type       in_left_ff;
   wst_pkg::cfg_type         cfg_ff, cfg_in;
   wst_pkg::track_state_type state_ff, state_in;
   logic                     out_valid_ff;
   wst_pkg::result_type      out_ff, out_in;
   logic                     advance;

   // move the held item on when the output register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   wst_step_logic u_step (
      .op          (in_op_ff),
      .right_count (in_right_ff),
      .left_count  (in_left_ff),
      .cfg         (cfg_ff),
      .state_cur   (state_ff),
      .state_nxt   (state_in),
      .result      (out_in)
   );

   // decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (wst_pkg::csr_index_type'(csr_index))
            wst_pkg::CSR_TOTAL_TICKS:  cfg_in.move_length = csr_data;
            wst_pkg::CSR_MOTION_MODE:
               cfg_in.motion_mode = csr_data[wst_pkg::MODE_BITS-1:0];
            wst_pkg::CSR_TRAJ_STEP:
               cfg_in.trajectory_step = csr_data[wst_pkg::STEP_BITS-1:0];
            wst_pkg::CSR_ERROR_TOL:
               cfg_in.error_tolerance = csr_data[wst_pkg::STEP_BITS-1:0];
            wst_pkg::CSR_SETTLE_TICKS:
               cfg_in.settle_ticks_needed = csr_data[wst_pkg::SETTLE_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // control and config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '0;
         state_ff     <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: capture on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff    <= req_op;
         in_right_ff <= req_right_count;
         in_left_ff  <= req_left_count;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_right_setpoint = out_ff.right_setpoint;
   assign rsp_left_setpoint  = out_ff.left_setpoint;
   assign rsp_drive_valid    = out_ff.drive_valid;
   assign rsp_finished       = out_ff.finished;

endmodule
`default_nettype wire

// File: hdl/wst_step_logic.sv
// Combinational work for one item: setpoints, cursor advance and end check.
// Depends on wst_pkg; instantiated by wheel_step_trajectory_tracker.
`default_nettype none
module wst_step_logic (
   input  wire logic                     op,
   input  wire wst_pkg::count_type       right_count,
   input  wire wst_pkg::count_type       left_count,
   input  wire wst_pkg::cfg_type         cfg,
   input  wire wst_pkg::track_state_type state_cur,
   output wst_pkg::track_state_type      state_nxt,
   output wst_pkg::result_type           result
);

   localparam wst_pkg::err_type COUNT_MAX =
      wst_pkg::err_type'({1'b0, {(wst_pkg::COUNT_BITS-1){1'b1}}});
   localparam wst_pkg::err_type COUNT_MIN = -COUNT_MAX - wst_pkg::err_type'(1);
   localparam wst_pkg::settle_type SETTLE_MAX = '1;

   logic              is_start;
   logic              do_drive;
   logic              new_rneg;
   logic              new_lneg;
   wst_pkg::count_type new_rref;
   wst_pkg::count_type new_lref;
   wst_pkg::err_type  rc_e, lc_e, rref_e, lref_e, cur_e, tot_e, step_e, tol_e;
   wst_pkg::err_type  rsum, lsum, rsat, lsat;
   wst_pkg::err_type  rtrack, ltrack, cur_gap, cand;
   logic              track_ok, snap;
   wst_pkg::cursor_type cursor_adv;
   wst_pkg::err_type  rtarget, ltarget, rend, lend;
   logic              settled;
   wst_pkg::settle_type settle_base, settle_new;

   always_comb begin
      is_start = (op == wst_pkg::OP_START);
      do_drive = !is_start && !state_cur.move_done;

      rc_e   = wst_pkg::ext_count(right_count);
      lc_e   = wst_pkg::ext_count(left_count);
      rref_e = wst_pkg::ext_count(state_cur.right_reference);
      lref_e = wst_pkg::ext_count(state_cur.left_reference);
      cur_e  = wst_pkg::ext_total(state_cur.progress_cursor);
      tot_e  = wst_pkg::ext_total(cfg.move_length);
      step_e = wst_pkg::ext_small(cfg.trajectory_step);
      tol_e  = wst_pkg::ext_small(cfg.error_tolerance);

      // setpoints: reference plus signed cursor, saturated to the count range
      rsum = rref_e + (state_cur.right_negative ? -cur_e : cur_e);
      lsum = lref_e + (state_cur.left_negative ? -cur_e : cur_e);
      rsat = (rsum > COUNT_MAX) ? COUNT_MAX : ((rsum < COUNT_MIN) ? COUNT_MIN : rsum);
      lsat = (lsum > COUNT_MAX) ? COUNT_MAX : ((lsum < COUNT_MIN) ? COUNT_MIN : lsum);

      // advance the cursor when both wheels track within one step of it
      rtrack   = cur_e - wst_pkg::abs_err(rc_e - rref_e);
      ltrack   = cur_e - wst_pkg::abs_err(lc_e - lref_e);
      track_ok = (rtrack <= step_e) && (rtrack >= -step_e) &&
                 (ltrack <= step_e) && (ltrack >= -step_e);
      cur_gap  = wst_pkg::abs_err(cur_e - tot_e);
      snap     = (cur_gap < tol_e);
      cand     = snap ? tot_e : (cur_e + step_e);
      if (cand > tot_e) begin
         cand = tot_e;
      end
      cursor_adv = track_ok ? wst_pkg::cursor_type'(cand[wst_pkg::TOTAL_BITS-1:0])
                            : state_cur.progress_cursor;

      // start latches references and signs from the motion mode
      new_rneg = state_cur.right_negative;
      new_lneg = state_cur.left_negative;
      new_rref = state_cur.right_reference;
      new_lref = state_cur.left_reference;
      if (is_start) begin
         new_rneg = (cfg.motion_mode == wst_pkg::MODE_BACKWARD) ||
                    (cfg.motion_mode == wst_pkg::MODE_CW);
         new_lneg = (cfg.motion_mode == wst_pkg::MODE_BACKWARD) ||
                    (cfg.motion_mode == wst_pkg::MODE_CCW);
         new_rref = right_count;
         new_lref = left_count;
      end

      // end check on the (possibly new) references
      rtarget = wst_pkg::ext_count(new_rref) + (new_rneg ? -tot_e : tot_e);
      ltarget = wst_pkg::ext_count(new_lref) + (new_lneg ? -tot_e : tot_e);
      rend    = wst_pkg::abs_err(rtarget) - wst_pkg::abs_err(rc_e);
      lend    = wst_pkg::abs_err(ltarget) - wst_pkg::abs_err(lc_e);
      settled = (tol_e >= rend) && (tol_e >= lend);

      // count settled items, saturating
      settle_base = is_start ? '0 : state_cur.settle_count;
      settle_new  = (settled && (settle_base != SETTLE_MAX))
                    ? settle_base + wst_pkg::settle_type'(1) : settle_base;

      state_nxt.right_reference = new_rref;
      state_nxt.left_reference  = new_lref;
      state_nxt.right_negative  = new_rneg;
      state_nxt.left_negative   = new_lneg;
      state_nxt.settle_count    = settle_new;
      state_nxt.move_done       = (settle_new >= cfg.settle_ticks_needed);
      if (is_start) begin
         state_nxt.progress_cursor = '0;
      end else if (do_drive) begin
         state_nxt.progress_cursor = cursor_adv;
      end else begin
         state_nxt.progress_cursor = state_cur.progress_cursor;
      end

      result.right_setpoint = do_drive ?
         wst_pkg::count_type'(rsat[wst_pkg::COUNT_BITS-1:0]) : '0;
      result.left_setpoint  = do_drive ?
         wst_pkg::count_type'(lsat[wst_pkg::COUNT_BITS-1:0]) : '0;
      result.drive_valid    = do_drive;
      result.finished       = state_nxt.move_done;
   end

endmodule
`default_nettype wire
